/* rtl/ppm_pkg.sv */
// Shared types and constants for the binary PPM (P6) to RGBA stream decoder.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package ppm_pkg;

    // Field widths
    localparam int unsigned ByteW  = 8;
    localparam int unsigned DimW   = 25;
    localparam int unsigned AreaW  = 2 * DimW;
    localparam int unsigned MaxvW  = 16;
    localparam int unsigned IdxW   = 24;
    localparam int unsigned KindW  = 2;
    localparam int unsigned ErrW   = 3;
    localparam int unsigned NumIdxW = 2;

    // Default limit on width*height
    localparam int unsigned MAX_PIXELS_DEF = 16777216;

    // Saturation value of the decimal accumulators
    localparam logic [DimW-1:0] AccMax = {DimW{1'b1}};

    // Result kinds
    localparam logic [KindW-1:0] KIND_HEADER = 2'd0;
    localparam logic [KindW-1:0] KIND_PIXEL  = 2'd1;
    localparam logic [KindW-1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [ErrW-1:0] ERR_NONE      = 3'd0;
    localparam logic [ErrW-1:0] ERR_MAGIC     = 3'd1;
    localparam logic [ErrW-1:0] ERR_NUMBER    = 3'd2;
    localparam logic [ErrW-1:0] ERR_NO_SPACE  = 3'd3;
    localparam logic [ErrW-1:0] ERR_TOO_LARGE = 3'd4;

    // Header number being parsed
    localparam logic [NumIdxW-1:0] NUM_WIDTH  = 2'd0;
    localparam logic [NumIdxW-1:0] NUM_HEIGHT = 2'd1;
    localparam logic [NumIdxW-1:0] NUM_MAXVAL = 2'd2;

    localparam logic [ByteW-1:0] ALPHA_OPAQUE = 8'hFF;

    // One input request
    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             start_image;
    } t_in;

    // One result
    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [DimW-1:0]  image_width;
        logic [DimW-1:0]  image_height;
        logic [MaxvW-1:0] max_value;
        logic [ByteW-1:0] red;
        logic [ByteW-1:0] green;
        logic [ByteW-1:0] blue;
        logic [ByteW-1:0] alpha;
        logic [IdxW-1:0]  dest_index;
        logic             last_pixel;
        logic [ErrW-1:0]  error_code;
    } t_out;

    // Start-of-pixels load from the header parser to the pixel unit
    typedef struct packed {
        logic            load;
        logic            two_byte;
        logic [DimW-1:0] width;
        logic [IdxW-1:0] row_base;
    } t_pix_load;

endpackage

`default_nettype wire

/* rtl/ppm_p6_to_rgba_stream.sv */
// Binary PPM (P6) decoder, one file byte per request, RGBA pixels out.
// Input channel: i_in_valid / o_in_ready carry data_byte and start_image; a
// request with start_image set begins a new file and restarts the parser.
// Output channel: o_out_valid / i_out_ready carry one result: a header
// (width, height, maxval), a pixel (RGBA, alpha 255, vertically flipped
// destination index) or an error code. After an error or the last pixel
// further bytes give nothing until the next start_image.
// Throughput: one byte per cycle while o_in_ready is high. Each byte passes through the
// parser and pixel logic in one step into the result register, so a result
// shows on o_out_valid in the cycle after its byte is taken.
// Stall: o_in_ready is high while the result register is empty or its result
// is taken in the same cycle; a receiver stall therefore holds the input only
// while a result is waiting.
// Reset (i_rst_n low, synchronous): the parser expects the magic 'P' and the
// result register is emptied. width*height comes from a registered multiplier
// that settles while maxval is being read.
// Depends on ppm_pkg, ppm_dim_mul, ppm_hdr and ppm_pix.
`default_nettype none

module ppm_p6_to_rgba_stream #(
    parameter int unsigned MAX_PIXELS = ppm_pkg::MAX_PIXELS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ppm_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ppm_pkg::t_out      o_out_data
);

    localparam int unsigned PixW = $clog2(MAX_PIXELS + 1);

    logic                       v_take;
    logic [ppm_pkg::DimW-1:0]   w_width;
    logic [ppm_pkg::DimW-1:0]   w_height;
    logic [ppm_pkg::AreaW-1:0]  w_area;
    logic                       w_pix_step;
    logic                       w_pix_done;
    ppm_pkg::t_pix_load         w_load;
    logic [PixW-1:0]            w_load_count;
    logic                       w_hdr_valid;
    ppm_pkg::t_out              w_hdr_res;
    logic                       w_pix_valid;
    ppm_pkg::t_out              w_pix_res;

    logic                       r_out_valid, n_out_valid;
    ppm_pkg::t_out              r_out_data, n_out_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign v_take     = i_in_valid && o_in_ready;

    ppm_dim_mul u_dim_mul (
        .i_clk    (i_clk),
        .i_width  (w_width),
        .i_height (w_height),
        .o_area   (w_area)
    );

    ppm_hdr #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_hdr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (v_take),
        .i_in         (i_in_data),
        .i_area       (w_area),
        .i_pix_done   (w_pix_done),
        .o_width      (w_width),
        .o_height     (w_height),
        .o_pix_step   (w_pix_step),
        .o_load       (w_load),
        .o_load_count (w_load_count),
        .o_res_valid  (w_hdr_valid),
        .o_res        (w_hdr_res)
    );

    ppm_pix #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_pix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_pix_step),
        .i_byte       (i_in_data.data_byte),
        .i_load       (w_load),
        .i_load_count (w_load_count),
        .o_done       (w_pix_done),
        .o_res_valid  (w_pix_valid),
        .o_res        (w_pix_res)
    );

    // Load the result register on a producing request, drop it when taken
    always_comb begin
        n_out_data = r_out_data;
        if (v_take) begin
            n_out_valid = w_hdr_valid || w_pix_valid;
            n_out_data  = w_pix_valid ? w_pix_res : w_hdr_res;
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* rtl/ppm_dim_mul.sv */
// Registered width*height product used by the header check.
// Depends on ppm_pkg for field widths.
`default_nettype none

module ppm_dim_mul (
    input  wire logic                       i_clk,
    input  wire logic [ppm_pkg::DimW-1:0]   i_width,
    input  wire logic [ppm_pkg::DimW-1:0]   i_height,
    output logic      [ppm_pkg::AreaW-1:0]  o_area
);

    logic [ppm_pkg::AreaW-1:0] r_area;
    logic [ppm_pkg::AreaW-1:0] n_area;

    // Multiply the held dimensions; maxval parsing leaves time for this to settle
    always_comb begin
        n_area = ppm_pkg::AreaW'(i_width) * ppm_pkg::AreaW'(i_height);
    end

    always_ff @(posedge i_clk) begin
        r_area <= n_area;
    end

    assign o_area = r_area;

endmodule

`default_nettype wire

/* rtl/ppm_hdr.sv */
// Header parser: magic, width, height, maxval, and the header or error result.
// Depends on ppm_pkg; takes the registered area from ppm_dim_mul.
`default_nettype none

module ppm_hdr #(
    parameter int unsigned MAX_PIXELS = ppm_pkg::MAX_PIXELS_DEF,
    localparam int unsigned PixW = $clog2(MAX_PIXELS + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_take,
    input  wire ppm_pkg::t_in               i_in,
    input  wire logic [ppm_pkg::AreaW-1:0]  i_area,
    input  wire logic                       i_pix_done,
    output logic      [ppm_pkg::DimW-1:0]   o_width,
    output logic      [ppm_pkg::DimW-1:0]   o_height,
    output logic                            o_pix_step,
    output ppm_pkg::t_pix_load              o_load,
    output logic      [PixW-1:0]            o_load_count,
    output logic                            o_res_valid,
    output ppm_pkg::t_out                   o_res
);

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam int unsigned AccSumW = ppm_pkg::DimW + 4;

    typedef enum logic [7:0] {
        PH_P       = 8'b0000_0001,
        PH_SIX     = 8'b0000_0010,
        PH_GAP     = 8'b0000_0100,
        PH_COMMENT = 8'b0000_1000,
        PH_POST    = 8'b0001_0000,
        PH_DIGITS  = 8'b0010_0000,
        PH_PIXELS  = 8'b0100_0000,
        PH_HALT    = 8'b1000_0000
    } t_phase;

    function automatic ppm_pkg::t_out err_result(input logic [ppm_pkg::ErrW-1:0] code);
        ppm_pkg::t_out res;
        res            = '0;
        res.kind       = ppm_pkg::KIND_ERROR;
        res.error_code = code;
        return res;
    endfunction

    t_phase                          r_phase, n_phase;
    logic [ppm_pkg::NumIdxW-1:0]     r_num_idx, n_num_idx;
    logic [ppm_pkg::DimW-1:0]        r_acc, n_acc;
    logic [ppm_pkg::DimW-1:0]        r_width, n_width;
    logic [ppm_pkg::DimW-1:0]        r_height, n_height;

    t_phase                          v_phase;
    logic [7:0]                      v_byte;
    logic                            v_space;
    logic                            v_digit;
    logic [3:0]                      v_dval;
    logic [AccSumW-1:0]              v_acc_sum;
    logic [ppm_pkg::DimW-1:0]        v_acc_sat;
    logic                            v_gap_ok;

    // Decode the byte class and the saturating decimal step
    always_comb begin
        v_byte    = i_in.data_byte;
        v_space   = (v_byte == CH_SPACE) || (v_byte == CH_TAB) ||
                    (v_byte == CH_LF) || (v_byte == CH_CR);
        v_digit   = (v_byte >= CH_ZERO) && (v_byte <= CH_NINE);
        v_dval    = 4'(v_byte - CH_ZERO);
        v_acc_sum = AccSumW'({r_acc, 3'b000}) + AccSumW'({r_acc, 1'b0}) + AccSumW'(v_dval);
        v_acc_sat = (v_acc_sum > AccSumW'(ppm_pkg::AccMax)) ? ppm_pkg::AccMax
                                                            : v_acc_sum[ppm_pkg::DimW-1:0];
        v_phase   = i_in.start_image ? PH_P : r_phase;
        v_gap_ok  = v_space || (v_byte == CH_HASH);
    end

    // Advance the header state and build the header or error result
    always_comb begin
        n_phase      = r_phase;
        n_num_idx    = r_num_idx;
        n_acc        = r_acc;
        n_width      = r_width;
        n_height     = r_height;
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_load       = '0;
        o_load_count = i_area[PixW-1:0];
        o_pix_step   = i_take && (v_phase == PH_PIXELS);

        if (i_take) begin
            case (v_phase)
                PH_P: begin
                    if (v_byte == CH_P) begin
                        n_phase = PH_SIX;
                    end else begin
                        n_phase     = PH_HALT;
                        o_res_valid = 1'b1;
                        o_res       = err_result(ppm_pkg::ERR_MAGIC);
                    end
                end
                PH_SIX: begin
                    if (v_byte == CH_SIX) begin
                        n_phase   = PH_GAP;
                        n_num_idx = ppm_pkg::NUM_WIDTH;
                    end else begin
                        n_phase     = PH_HALT;
                        o_res_valid = 1'b1;
                        o_res       = err_result(ppm_pkg::ERR_MAGIC);
                    end
                end
                PH_COMMENT: begin
                    if (v_byte == CH_LF || v_byte == CH_CR) begin
                        n_phase = PH_POST;
                    end
                end
                PH_GAP, PH_POST: begin
                    if (v_space) begin
                        n_phase = v_phase;
                    end else if (v_phase == PH_GAP && v_byte == CH_HASH) begin
                        n_phase = PH_COMMENT;
                    end else if (v_digit) begin
                        n_acc   = ppm_pkg::DimW'(v_dval);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase     = PH_HALT;
                        o_res_valid = 1'b1;
                        o_res       = err_result(ppm_pkg::ERR_NUMBER);
                    end
                end
                PH_DIGITS: begin
                    if (v_digit) begin
                        n_acc = v_acc_sat;
                    end else if (r_num_idx == ppm_pkg::NUM_WIDTH ||
                                 r_num_idx == ppm_pkg::NUM_HEIGHT) begin
                        // Close width or height and open the next gap
                        if (r_num_idx == ppm_pkg::NUM_WIDTH) begin
                            n_width = r_acc;
                        end else begin
                            n_height = r_acc;
                        end
                        n_num_idx = r_num_idx + 1'b1;
                        if (v_gap_ok) begin
                            n_phase = v_space ? PH_GAP : PH_COMMENT;
                        end else begin
                            n_phase     = PH_HALT;
                            o_res_valid = 1'b1;
                            o_res       = err_result(ppm_pkg::ERR_NUMBER);
                        end
                    end else if (!v_space) begin
                        n_phase     = PH_HALT;
                        o_res_valid = 1'b1;
                        o_res       = err_result(ppm_pkg::ERR_NO_SPACE);
                    end else if (i_area > ppm_pkg::AreaW'(MAX_PIXELS)) begin
                        n_phase     = PH_HALT;
                        o_res_valid = 1'b1;
                        o_res       = err_result(ppm_pkg::ERR_TOO_LARGE);
                    end else begin
                        // Header accepted: load the pixel unit
                        n_phase            = (i_area != '0) ? PH_PIXELS : PH_HALT;
                        o_res_valid        = 1'b1;
                        o_res.kind         = ppm_pkg::KIND_HEADER;
                        o_res.image_width  = r_width;
                        o_res.image_height = r_height;
                        o_res.max_value    = (r_acc > ppm_pkg::DimW'(16'hFFFF)) ?
                                             16'hFFFF : r_acc[ppm_pkg::MaxvW-1:0];
                        o_res.last_pixel   = (i_area == '0);
                        o_load.load        = 1'b1;
                        o_load.two_byte    = (r_acc > ppm_pkg::DimW'(8'hFF));
                        o_load.width       = r_width;
                        o_load.row_base    = (r_height == '0) ? '0 :
                                             i_area[ppm_pkg::IdxW-1:0] -
                                             r_width[ppm_pkg::IdxW-1:0];
                    end
                end
                PH_PIXELS: begin
                    if (i_pix_done) begin
                        n_phase = PH_HALT;
                    end
                end
                PH_HALT: begin
                    n_phase = PH_HALT;
                end
                default: begin
                    n_phase = PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_P;
            r_num_idx <= ppm_pkg::NUM_WIDTH;
        end else begin
            r_phase   <= n_phase;
            r_num_idx <= n_num_idx;
        end
    end

    // Hold number payloads
    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_width  <= n_width;
        r_height <= n_height;
    end

    assign o_width  = r_width;
    assign o_height = r_height;

endmodule

`default_nettype wire

/* rtl/ppm_pix.sv */
// Pixel unit: groups sample bytes into RGBA pixels with a flipped destination index.
// Depends on ppm_pkg; loaded by ppm_hdr when a header is accepted.
`default_nettype none

module ppm_pix #(
    parameter int unsigned MAX_PIXELS = ppm_pkg::MAX_PIXELS_DEF,
    localparam int unsigned PixW = $clog2(MAX_PIXELS + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_step,
    input  wire logic [ppm_pkg::ByteW-1:0] i_byte,
    input  wire ppm_pkg::t_pix_load       i_load,
    input  wire logic [PixW-1:0]          i_load_count,
    output logic                          o_done,
    output logic                          o_res_valid,
    output ppm_pkg::t_out                 o_res
);

    logic [2:0]               r_pos, n_pos;
    logic                     r_two, n_two;
    logic [ppm_pkg::ByteW-1:0] r_red, n_red;
    logic [ppm_pkg::ByteW-1:0] r_green, n_green;
    logic [ppm_pkg::DimW-1:0] r_col, n_col;
    logic [ppm_pkg::DimW-1:0] r_width, n_width;
    logic [ppm_pkg::IdxW-1:0] r_row_base, n_row_base;
    logic [PixW-1:0]          r_left, n_left;

    logic [2:0]               v_mid, v_end, v_span, v_pos1;
    logic [PixW-1:0]          v_left_dec;
    logic [ppm_pkg::DimW-1:0] v_col1;
    logic                     v_emit;

    // Place the byte in the pixel and step the raster counters
    always_comb begin
        v_mid      = r_two ? 3'd2 : 3'd1;
        v_end      = r_two ? 3'd4 : 3'd2;
        v_span     = r_two ? 3'd6 : 3'd3;
        v_pos1     = r_pos + 3'd1;
        v_emit     = i_step && (r_pos == v_end);
        v_left_dec = (r_left != '0) ? r_left - 1'b1 : r_left;
        v_col1     = r_col + 1'b1;

        n_pos      = r_pos;
        n_two      = r_two;
        n_red      = r_red;
        n_green    = r_green;
        n_col      = r_col;
        n_width    = r_width;
        n_row_base = r_row_base;
        n_left     = r_left;

        o_res_valid = v_emit;
        o_done      = v_emit && (v_left_dec == '0);
        o_res       = '0;

        if (i_load.load) begin
            n_pos      = '0;
            n_two      = i_load.two_byte;
            n_col      = '0;
            n_width    = i_load.width;
            n_row_base = i_load.row_base;
            n_left     = i_load_count;
        end else if (i_step) begin
            n_pos = (v_pos1 >= v_span) ? 3'd0 : v_pos1;
            if (r_pos == 3'd0) begin
                n_red = i_byte;
            end
            if (r_pos == v_mid) begin
                n_green = i_byte;
            end
            if (v_emit) begin
                n_left = v_left_dec;
                if (v_col1 >= r_width) begin
                    n_col      = '0;
                    n_row_base = (r_row_base >= r_width[ppm_pkg::IdxW-1:0] &&
                                  r_width[ppm_pkg::DimW-1] == 1'b0) ?
                                 r_row_base - r_width[ppm_pkg::IdxW-1:0] : '0;
                end else begin
                    n_col = v_col1;
                end
            end
        end

        if (v_emit) begin
            o_res.kind       = ppm_pkg::KIND_PIXEL;
            o_res.red        = r_red;
            o_res.green      = r_green;
            o_res.blue       = i_byte;
            o_res.alpha      = ppm_pkg::ALPHA_OPAQUE;
            o_res.dest_index = r_row_base + r_col[ppm_pkg::IdxW-1:0];
            o_res.last_pixel = (v_left_dec == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_left <= '0;
        end else begin
            r_pos  <= n_pos;
            r_left <= n_left;
        end
    end

    // Hold pixel payload and raster position
    always_ff @(posedge i_clk) begin
        r_two      <= n_two;
        r_red      <= n_red;
        r_green    <= n_green;
        r_col      <= n_col;
        r_width    <= n_width;
        r_row_base <= n_row_base;
    end

endmodule

`default_nettype wire

/* test/ppm_p6_to_rgba_stream_tb.sv */
// Self-checking testbench for ppm_p6_to_rgba_stream: feeds P6 files byte by byte and checks
// every header, pixel and error result against a decoder written in the bench itself.
// Depends on ppm_pkg and the ppm_p6_to_rgba_stream rtl.
`timescale 1ns / 100ps

module ppm_p6_to_rgba_stream_tb;
    import ppm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned STIM_BYTES  = 680;
    localparam int unsigned DRAIN_CYCLES = 8;

    localparam longint unsigned PIXEL_LIMIT = MAX_PIXELS_DEF;
    localparam longint unsigned IdxMask     = 64'hFF_FFFF;
    localparam int unsigned     ONE_BYTE_MAX = 255;
    localparam int unsigned     MAXV_SAT     = 65535;

    // Characters that matter to the header syntax
    localparam logic [ByteW-1:0] CH_P     = 8'h50;
    localparam logic [ByteW-1:0] CH_SIX   = 8'h36;
    localparam logic [ByteW-1:0] CH_HASH  = 8'h23;
    localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
    localparam logic [ByteW-1:0] CH_TAB   = 8'h09;
    localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
    localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
    localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
    localparam logic [ByteW-1:0] CH_NINE  = 8'h39;
    localparam logic [ByteW-1:0] CH_PLUS  = 8'h2B;
    localparam logic [ByteW-1:0] CH_MINUS = 8'h2D;
    localparam logic [ByteW-1:0] CH_X     = 8'h78;
    localparam logic [ByteW-1:0] CH_VTAB  = 8'h0B;

    typedef enum logic [2:0] {ST_MAGIC_P, ST_MAGIC_6, ST_HEADER, ST_PIXELS, ST_HALT} t_stage;
    typedef enum logic [1:0] {FLD_GAP, FLD_COMMENT, FLD_POST, FLD_DIGITS} t_field;
    typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_RUNS} t_sink;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_ready;
    t_out  o_out_data;

    // Pending requests and results still owed by the block
    t_in  req_queue[$];
    t_out owed_results[$];

    // Decoder state mirrored in the bench
    t_stage              stage;
    t_field              field;
    logic [NumIdxW-1:0]  num_sel;
    logic [DimW-1:0]     acc;
    logic [DimW-1:0]     wid;
    logic [DimW-1:0]     hgt;
    logic                wide_samples;
    int unsigned         byte_pos;
    logic [ByteW-1:0]    red_q;
    logic [ByteW-1:0]    green_q;
    int unsigned         col;
    int unsigned         row_base;
    logic [DimW-1:0]     left;

    bit          req_taken;
    t_out        predicted;
    t_out        owed;
    int unsigned burst_left;
    int unsigned gap_left;
    t_sink       sink_mode;
    int unsigned mode_left;
    int unsigned run_left;
    logic        sink_ready;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    ppm_p6_to_rgba_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit is_blank(logic [ByteW-1:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic bit is_digit(logic [ByteW-1:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic void clear_decoder();
        stage        = ST_MAGIC_P;
        field        = FLD_GAP;
        num_sel      = NUM_WIDTH;
        acc          = '0;
        wid          = '0;
        hgt          = '0;
        wide_samples = 1'b0;
        byte_pos     = 0;
        red_q        = '0;
        green_q      = '0;
        col          = 0;
        row_base     = 0;
        left         = '0;
    endfunction

    function automatic bit flag_error(output t_out res, input logic [ErrW-1:0] code);
        res            = '0;
        res.kind       = KIND_ERROR;
        res.error_code = code;
        stage          = ST_HALT;
        return 1'b1;
    endfunction

    // Advance the decoder by one file byte; return 1 when the byte yields a result
    function automatic bit decode_byte(input t_in req, output t_out res);
        logic [ByteW-1:0] b;
        longint unsigned  grown;
        longint unsigned  area;
        logic [MaxvW-1:0] maxv;
        int unsigned      stride;
        int unsigned      pos;
        bit               emitted;
        res = '0;
        b   = req.data_byte;
        if (req.start_image) clear_decoder();
        case (stage)
            ST_MAGIC_P: begin
                if (b != CH_P) return flag_error(res, ERR_MAGIC);
                stage = ST_MAGIC_6;
                return 1'b0;
            end
            ST_MAGIC_6: begin
                if (b != CH_SIX) return flag_error(res, ERR_MAGIC);
                stage   = ST_HEADER;
                field   = FLD_GAP;
                num_sel = NUM_WIDTH;
                return 1'b0;
            end
            ST_HEADER: begin
                case (field)
                    FLD_COMMENT: begin
                        if (b == CH_LF || b == CH_CR) field = FLD_POST;
                        return 1'b0;
                    end
                    FLD_DIGITS: begin
                        if (is_digit(b)) begin
                            grown = longint'(acc) * 10 + longint'(b - CH_ZERO);
                            acc   = (grown > AccMax) ? AccMax : DimW'(grown);
                            return 1'b0;
                        end
                        // width and height close on a blank or a comment
                        if (num_sel != NUM_MAXVAL) begin
                            if (num_sel == NUM_WIDTH) begin
                                wid     = acc;
                                num_sel = NUM_HEIGHT;
                            end else begin
                                hgt     = acc;
                                num_sel = NUM_MAXVAL;
                            end
                            if (is_blank(b)) field = FLD_GAP;
                            else if (b == CH_HASH) field = FLD_COMMENT;
                            else return flag_error(res, ERR_NUMBER);
                            return 1'b0;
                        end
                        // maxval closes the header on exactly one blank
                        if (!is_blank(b)) return flag_error(res, ERR_NO_SPACE);
                        maxv = (acc > MAXV_SAT) ? MaxvW'(MAXV_SAT) : acc[MaxvW-1:0];
                        area = longint'(wid) * longint'(hgt);
                        if (area > PIXEL_LIMIT) return flag_error(res, ERR_TOO_LARGE);
                        wide_samples = (maxv > ONE_BYTE_MAX);
                        left         = DimW'(area);
                        col          = 0;
                        byte_pos     = 0;
                        row_base     = (hgt != 0) ?
                            32'(((longint'(hgt) - 1) * longint'(wid)) & IdxMask) : 0;
                        stage            = (area != 0) ? ST_PIXELS : ST_HALT;
                        res.kind         = KIND_HEADER;
                        res.image_width  = wid;
                        res.image_height = hgt;
                        res.max_value    = maxv;
                        res.last_pixel   = (area == 0);
                        return 1'b1;
                    end
                    default: begin
                        if (is_blank(b)) return 1'b0;
                        if (field == FLD_GAP && b == CH_HASH) begin
                            field = FLD_COMMENT;
                            return 1'b0;
                        end
                        if (is_digit(b)) begin
                            acc   = DimW'(b - CH_ZERO);
                            field = FLD_DIGITS;
                            return 1'b0;
                        end
                        return flag_error(res, ERR_NUMBER);
                    end
                endcase
            end
            ST_PIXELS: begin
                stride  = wide_samples ? 2 : 1;
                pos     = byte_pos;
                emitted = 1'b0;
                if (pos == 0) begin
                    red_q = b;
                end else if (pos == stride) begin
                    green_q = b;
                end else if (pos == 2 * stride) begin
                    res.kind       = KIND_PIXEL;
                    res.red        = red_q;
                    res.green      = green_q;
                    res.blue       = b;
                    res.alpha      = ALPHA_OPAQUE;
                    res.dest_index = IdxW'(row_base + col);
                    if (left != 0) left = left - 1'b1;
                    res.last_pixel = (left == 0);
                    col++;
                    // step the destination row upward at the end of each line
                    if (col >= wid) begin
                        col      = 0;
                        row_base = (row_base >= wid) ? row_base - wid : 0;
                    end
                    if (left == 0) stage = ST_HALT;
                    emitted = 1'b1;
                end
                pos++;
                byte_pos = (pos >= 3 * stride) ? 0 : pos;
                return emitted;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Stimulus builders

    task automatic add_byte(logic [ByteW-1:0] b, logic first);
        t_in req;
        req.data_byte   = b;
        req.start_image = first;
        req_queue.push_back(req);
    endtask

    task automatic add_text(string s, logic first);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], first && i == 0);
    endtask

    function automatic logic [ByteW-1:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // Emit whitespace with an optional comment; optionally a forbidden second comment
    task automatic add_gap(bit needed, bit second_comment);
        bit          with_comment;
        int unsigned n;
        logic [ByteW-1:0] c;
        with_comment = second_comment || ($urandom_range(0, 3) == 0);
        n = $urandom_range((needed && !with_comment) ? 1 : 0, 2);
        repeat (n) add_byte(pick_blank(), 1'b0);
        if (with_comment) begin
            add_byte(CH_HASH, 1'b0);
            repeat ($urandom_range(0, 5)) begin
                c = 8'($urandom);
                add_byte((c == CH_LF || c == CH_CR) ? CH_X : c, 1'b0);
            end
            add_byte($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
            repeat ($urandom_range(0, 2)) add_byte(pick_blank(), 1'b0);
            if (second_comment) add_byte(CH_HASH, 1'b0);
        end
    endtask

    // Saturated values are written with more digits than fit
    task automatic add_number(logic [DimW-1:0] v);
        if (v == AccMax) begin
            repeat ($urandom_range(9, 14)) add_byte(CH_NINE, 1'b0);
        end else begin
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) add_byte(CH_ZERO, 1'b0);
            add_text($sformatf("%0d", v), 1'b0);
        end
    endtask

    function automatic logic [DimW-1:0] pick_dim();
        case ($urandom_range(0, 23))
            0: return '0;
            1: return 4096;
            2: return AccMax;
            3: return 16777216;
            4: return 16777217;
            5: return 1;
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    function automatic logic [DimW-1:0] pick_maxval();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return 1;
            2: return 255;
            3: return 256;
            4: return 65535;
            5: return 65536;
            6: return AccMax;
            7, 8: return $urandom_range(256, 1000);
            default: return $urandom_range(1, 255);
        endcase
    endfunction

    // Queue one file: mostly well-formed with random content, some noise and faults
    task automatic add_file();
        int unsigned     fault;
        int unsigned     npix;
        int unsigned     per_pixel;
        logic [DimW-1:0] w;
        logic [DimW-1:0] h;
        logic [DimW-1:0] mv;
        longint unsigned area;
        if ($urandom_range(0, 99) < 10) begin
            add_byte($urandom_range(0, 2) == 0 ? CH_P : 8'($urandom), 1'b1);
            repeat ($urandom_range(0, 5)) add_byte(8'($urandom), 1'b0);
            return;
        end
        fault = $urandom_range(0, 19);
        w  = pick_dim();
        h  = pick_dim();
        mv = pick_maxval();
        if ($urandom_range(0, 15) == 0) begin
            w = 4096;
            h = 4096 + $urandom_range(0, 1);
        end
        add_byte(fault == 1 ? 8'($urandom) : CH_P, 1'b1);
        add_byte(fault == 2 ? 8'($urandom) : CH_SIX, 1'b0);
        add_gap(1'b0, fault == 3);
        if (fault == 4) add_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
        add_number(w);
        add_gap(1'b1, fault == 5);
        add_number(h);
        add_gap(1'b1, 1'b0);
        if (fault == 6) add_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
        add_number(mv);
        if (fault == 7) begin
            case ($urandom_range(0, 2))
                0: add_byte(CH_HASH, 1'b0);
                1: add_byte(CH_X, 1'b0);
                default: add_byte(CH_VTAB, 1'b0);
            endcase
        end else begin
            add_byte(pick_blank(), 1'b0);
        end
        // Pixel data: whole image when small, else a few pixels; sometimes cut short before the next file
        area      = longint'(w) * longint'(h);
        per_pixel = (mv > ONE_BYTE_MAX) ? 6 : 3;
        npix      = (area <= 25) ? int'(area) : $urandom_range(1, 5);
        if (npix != 0 && $urandom_range(0, 7) == 0) npix = $urandom_range(0, npix - 1);
        repeat (npix * per_pixel) add_byte(8'($urandom), 1'b0);
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) add_byte(8'($urandom), 1'b0);
    endtask

    // Record each accepted request and predict what it yields
    always @(posedge i_clk) begin
        req_taken = i_rst_n && i_in_valid && o_in_ready;
        if (req_taken && decode_byte(i_in_data, predicted)) owed_results.push_back(predicted);
    end

    // Present the next request in bursts separated by random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (req_taken || !i_in_valid)) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (req_queue.size() != 0) begin
                i_in_data  <= req_queue.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side: free-running, random, or long runs of back-pressure
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            sink_mode = t_sink'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 80);
        end else begin
            mode_left--;
        end
        case (sink_mode)
            SINK_OPEN:   sink_ready = 1'b1;
            SINK_RANDOM: sink_ready = ($urandom_range(0, 3) != 0);
            default: begin
                if (run_left == 0) begin
                    sink_ready = !sink_ready;
                    run_left   = sink_ready ? $urandom_range(1, 3) : $urandom_range(1, 8);
                end else begin
                    run_left--;
                end
            end
        endcase
        i_out_ready <= sink_ready;
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each taken result with the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_results.size() == 0) begin
                $error("kind: expected no result, got %0d", o_out_data.kind);
                mismatch_count++;
            end else begin
                owed = owed_results.pop_front();
                check_field("kind", owed.kind, o_out_data.kind);
                check_field("image_width", owed.image_width, o_out_data.image_width);
                check_field("image_height", owed.image_height, o_out_data.image_height);
                check_field("max_value", owed.max_value, o_out_data.max_value);
                check_field("red", owed.red, o_out_data.red);
                check_field("green", owed.green, o_out_data.green);
                check_field("blue", owed.blue, o_out_data.blue);
                check_field("alpha", owed.alpha, o_out_data.alpha);
                check_field("dest_index", owed.dest_index, o_out_data.dest_index);
                check_field("last_pixel", owed.last_pixel, o_out_data.last_pixel);
                check_field("error_code", owed.error_code, o_out_data.error_code);
            end
        end
    end

    // Hard stop if the run hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ppm_p6_to_rgba_stream_tb: errors");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        req_taken      = 1'b0;
        burst_left     = 1;
        gap_left       = 0;
        sink_mode      = SINK_OPEN;
        sink_ready     = 1'b0;
        mode_left      = 0;
        run_left       = 0;
        mismatch_count = 0;
        clear_decoder();

        // Directed: no start after reset with a bad second magic byte, a signed
        // width, an empty image with maxval zero, then a one-pixel image
        add_text("P5", 1'b0);
        add_text("P6-", 1'b1);
        add_text("P6 0 0 0 ", 1'b1);
        add_text("P6 1 1 0\n", 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hA5, 1'b0);

        while (req_queue.size() < STIM_BYTES) add_file();

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken, then for the owed results
        while (req_queue.size() != 0 || i_in_valid) @(posedge i_clk);
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("ppm_p6_to_rgba_stream_tb: clean");
        end else begin
            $display("ppm_p6_to_rgba_stream_tb: errors");
        end
        $finish;
    end

endmodule
